// ===== src/mma_pkg.sv =====
// shared types and constants for the modular arithmetic unit
package mma_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = WORD_W / 2;
   localparam int OPER_W = 256;
   localparam int ACC_W  = 2 * OPER_W + 1;
   localparam int SHF_W  = 3;
   localparam int CNT_W  = 5;
   localparam int BIT_W  = 8;
   localparam logic [CNT_W-1:0] MUL_COUNT = CNT_W'(16);
   localparam logic [CNT_W-1:0] MUL_DRAIN = CNT_W'(17);

   localparam logic [OPER_W-1:0] ORD_N =
      256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_7203DF6B21C6052B_53BBF40939D54123;
   localparam logic [OPER_W-1:0] NEG_N =
      256'h0000000100000000_0000000000000000_8DFC2094DE39FAD4_AC440BF6C62ABEDD;
   localparam logic [OPER_W-1:0] N_PRIME =
      256'h6F39132F82E4C7BC_2B0068D3B08941D4_DF1E8D34FC8319A5_327F9E8872350975;
   localparam logic [OPER_W-1:0] R_SQ =
      256'h1EB5E412A22B3D3B_620FC84C3AFFE0D4_3464504ADE6FA2FA_901192AF7C114F20;
   localparam logic [OPER_W-1:0] N_MINUS_2 =
      256'hFFFFFFFEFFFFFFFF_FFFFFFFFFFFFFFFF_7203DF6B21C6052B_53BBF40939D54121;
   localparam logic [OPER_W-1:0] ONE_VAL = 256'h1;

   typedef enum logic [2:0] {
      ACT_ADD  = 3'd0,
      ACT_SUB  = 3'd1,
      ACT_MUL  = 3'd2,
      ACT_TOM  = 3'd3,
      ACT_FROM = 3'd4,
      ACT_POW  = 3'd5,
      ACT_INV  = 3'd6
   } act_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_MUL,
      S_NEXT,
      S_ADDFIX,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_T,
      PH_M,
      PH_N
   } phase_type;

   typedef struct packed {
      logic             valid;
      logic [SHF_W-1:0] shift;
   } tag_type;

endpackage

// ===== src/mma_if.sv =====
// request and response channel interfaces
interface mma_req_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 action;
   logic [mma_pkg::WORD_W-1:0] a_w0;
   logic [mma_pkg::WORD_W-1:0] a_w1;
   logic [mma_pkg::WORD_W-1:0] a_w2;
   logic [mma_pkg::WORD_W-1:0] a_w3;
   logic [mma_pkg::WORD_W-1:0] b_w0;
   logic [mma_pkg::WORD_W-1:0] b_w1;
   logic [mma_pkg::WORD_W-1:0] b_w2;
   logic [mma_pkg::WORD_W-1:0] b_w3;
   modport source (output valid, action, a_w0, a_w1, a_w2, a_w3,
                   b_w0, b_w1, b_w2, b_w3, input ready);
   modport sink (input valid, action, a_w0, a_w1, a_w2, a_w3,
                 b_w0, b_w1, b_w2, b_w3, output ready);
endinterface

interface mma_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mma_pkg::WORD_W-1:0] r_w0;
   logic [mma_pkg::WORD_W-1:0] r_w1;
   logic [mma_pkg::WORD_W-1:0] r_w2;
   logic [mma_pkg::WORD_W-1:0] r_w3;
   modport source (output valid, r_w0, r_w1, r_w2, r_w3, input ready);
   modport sink (input valid, r_w0, r_w1, r_w2, r_w3, output ready);
endinterface

// ===== src/mma_mul64.sv =====
// two-stage 64x64 word multiplier from 32x32 partial products, with tag pipeline
module mma_mul64 (
   input  logic                         clock,
   input  logic                         reset,
   input  mma_pkg::tag_type             tag_in,
   input  logic [mma_pkg::WORD_W-1:0]   x,
   input  logic [mma_pkg::WORD_W-1:0]   y,
   output mma_pkg::tag_type             tag_out,
   output logic [2*mma_pkg::WORD_W-1:0] prod
);
   import mma_pkg::*;

   tag_type               tag1_ff;
   tag_type               tag2_ff;
   logic [WORD_W-1:0]     ll_ff;
   logic [WORD_W-1:0]     lh_ff;
   logic [WORD_W-1:0]     hl_ff;
   logic [WORD_W-1:0]     hh_ff;
   logic [2*WORD_W-1:0]   prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ll_ff   <= {{HALF_W{1'b0}}, x[HALF_W-1:0]} * {{HALF_W{1'b0}}, y[HALF_W-1:0]};
      lh_ff   <= {{HALF_W{1'b0}}, x[HALF_W-1:0]} * {{HALF_W{1'b0}}, y[WORD_W-1:HALF_W]};
      hl_ff   <= {{HALF_W{1'b0}}, x[WORD_W-1:HALF_W]} * {{HALF_W{1'b0}}, y[HALF_W-1:0]};
      hh_ff   <= {{HALF_W{1'b0}}, x[WORD_W-1:HALF_W]} * {{HALF_W{1'b0}}, y[WORD_W-1:HALF_W]};
      prod_ff <= {hh_ff, ll_ff}
               + {{HALF_W{1'b0}}, lh_ff, {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, hl_ff, {HALF_W{1'b0}}};
   end

   assign tag_out = tag2_ff;
   assign prod    = prod_ff;

endmodule

// ===== src/mma_core.sv =====
// sequencer and datapath around the shared word multiplier
module mma_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mma_pkg::act_type           act,
   input  logic [mma_pkg::OPER_W-1:0] a,
   input  logic [mma_pkg::OPER_W-1:0] b,
   input  logic                       take,
   output logic                       idle,
   output logic                       done,
   output logic [mma_pkg::OPER_W-1:0] result
);
   import mma_pkg::*;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   act_type              act_ff, act_in;
   logic [OPER_W-1:0]    opa_ff, opa_in;
   logic [OPER_W-1:0]    opb_ff, opb_in;
   logic [OPER_W-1:0]    x_ff, x_in;
   logic [OPER_W-1:0]    y_ff, y_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [2*OPER_W-1:0]  t_ff, t_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic                 sq_ff, sq_in;
   logic [OPER_W-1:0]    res_ff, res_in;

   tag_type              issue_tag;
   tag_type              out_tag;
   logic [WORD_W-1:0]    mul_x;
   logic [WORD_W-1:0]    mul_y;
   logic [2*WORD_W-1:0]  prod;

   logic                 is_sub;
   logic                 pow_act;
   logic [OPER_W-1:0]    ebits;
   logic                 ebit;
   logic                 pow_more_mul;
   logic                 pow_last;
   logic                 fix_sub;
   logic [OPER_W-1:0]    fix_t;
   logic                 fix_f;
   logic [OPER_W:0]      fix_sum;
   logic [OPER_W-1:0]    fix_res;
   logic [OPER_W:0]      as_sum;

   mma_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (issue_tag),
      .x       (mul_x),
      .y       (mul_y),
      .tag_out (out_tag),
      .prod    (prod)
   );

   assign is_sub       = (act_ff == ACT_SUB);
   assign pow_act      = (act_ff == ACT_POW) || (act_ff == ACT_INV);
   assign ebits        = (act_ff == ACT_INV) ? N_MINUS_2 : opb_ff;
   assign ebit         = ebits[bit_ff];
   assign pow_more_mul = sq_ff & ebit;
   assign pow_last     = (bit_ff == '0);

   // single correction adder shared by add, sub and reduction
   assign fix_sub = (state_ff == S_ADDFIX) && is_sub;
   assign fix_t   = (state_ff == S_ADDFIX) ? acc_ff[OPER_W-1:0] : acc_ff[2*OPER_W-1:OPER_W];
   assign fix_f   = (state_ff == S_ADDFIX) ? acc_ff[OPER_W] : acc_ff[ACC_W-1];
   assign fix_sum = {1'b0, fix_t} + {1'b0, (fix_sub ? ORD_N : NEG_N)};
   assign fix_res = fix_sub ? (fix_f ? fix_sum[OPER_W-1:0] : fix_t)
                            : ((fix_f | fix_sum[OPER_W]) ? fix_sum[OPER_W-1:0] : fix_t);

   assign as_sum = {1'b0, opa_ff} + {1'b0, (is_sub ? ~opb_ff : opb_ff)}
                 + {{OPER_W{1'b0}}, is_sub};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_START;
         end
         S_START: begin
            case (act_ff)
               ACT_ADD, ACT_SUB: state_in = S_ADDFIX;
               ACT_MUL, ACT_TOM, ACT_FROM, ACT_POW, ACT_INV: state_in = S_MUL;
               default: state_in = S_DONE;
            endcase
         end
         S_MUL: begin
            if (cnt_ff == MUL_DRAIN) state_in = S_NEXT;
         end
         S_NEXT: begin
            if (phase_ff != PH_N) state_in = S_MUL;
            else if (!pow_act) state_in = S_DONE;
            else if (pow_more_mul) state_in = S_MUL;
            else if (pow_last) state_in = S_DONE;
            else state_in = S_MUL;
         end
         S_ADDFIX: state_in = S_DONE;
         S_DONE: begin
            if (take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      act_in    = act_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      cnt_in    = cnt_ff;
      t_in      = t_ff;
      bit_in    = bit_ff;
      sq_in     = sq_ff;
      res_in    = res_ff;
      issue_tag = '0;
      mul_x     = x_ff[WORD_W*cnt_ff[3:2] +: WORD_W];
      mul_y     = y_ff[WORD_W*cnt_ff[1:0] +: WORD_W];
      acc_in    = out_tag.valid ? acc_ff + (ACC_W'(prod) << (WORD_W * out_tag.shift))
                                : acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in = act;
               opa_in = a;
               opb_in = b;
            end
         end
         S_START: begin
            cnt_in   = '0;
            phase_in = PH_T;
            acc_in   = '0;
            x_in     = opa_ff;
            case (act_ff)
               ACT_ADD: acc_in = ACC_W'(as_sum);
               ACT_SUB: acc_in = ACC_W'({~as_sum[OPER_W], as_sum[OPER_W-1:0]});
               ACT_MUL: y_in = opb_ff;
               ACT_TOM: y_in = R_SQ;
               ACT_FROM: y_in = ONE_VAL;
               ACT_POW, ACT_INV: begin
                  x_in   = NEG_N;
                  y_in   = NEG_N;
                  bit_in = '1;
                  sq_in  = 1'b1;
               end
               default: res_in = '0;
            endcase
         end
         S_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff < MUL_COUNT) begin
               issue_tag.valid = 1'b1;
               issue_tag.shift = {1'b0, cnt_ff[3:2]} + {1'b0, cnt_ff[1:0]};
            end
         end
         S_NEXT: begin
            cnt_in = '0;
            case (phase_ff)
               PH_T: begin
                  t_in     = acc_ff[2*OPER_W-1:0];
                  x_in     = acc_ff[OPER_W-1:0];
                  y_in     = N_PRIME;
                  acc_in   = '0;
                  phase_in = PH_M;
               end
               PH_M: begin
                  x_in     = acc_ff[OPER_W-1:0];
                  y_in     = ORD_N;
                  acc_in   = {1'b0, t_ff};
                  phase_in = PH_N;
               end
               default: begin
                  phase_in = PH_T;
                  acc_in   = '0;
                  if (!pow_act) begin
                     res_in = fix_res;
                  end else if (pow_more_mul) begin
                     x_in  = fix_res;
                     y_in  = opa_ff;
                     sq_in = 1'b0;
                  end else if (pow_last) begin
                     res_in = fix_res;
                  end else begin
                     x_in   = fix_res;
                     y_in   = fix_res;
                     sq_in  = 1'b1;
                     bit_in = bit_ff - 1'b1;
                  end
               end
            endcase
         end
         S_ADDFIX: res_in = fix_res;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_T;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      t_ff   <= t_in;
      bit_ff <= bit_in;
      sq_ff  <= sq_in;
      res_ff <= res_in;
   end

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign result = res_ff;

endmodule

// ===== src/modn_montgomery_alu_256.sv =====
// top level of the 256-bit arithmetic unit modulo the group order
//  channel   dir  handshake          payload
//  req_chan  in   valid/ready        action, a_w0..a_w3, b_w0..b_w3
//  rsp_chan  out  valid/ready        r_w0..r_w3
// add and sub finish in the correction adder; a montgomery multiply makes
// three passes of 16 word products through the one two-stage 64x64 multiplier
// power and inverse run 256 squarings plus one multiply per set exponent bit
// reset is synchronous; req_chan.ready is low while a transaction is in work
// a finished result sits in the output register so a new transaction can start
module modn_montgomery_alu_256 (
   input logic       clock,
   input logic       reset,
   mma_req_if.sink   req_chan,
   mma_rsp_if.source rsp_chan
);
   import mma_pkg::*;

   logic                 start;
   logic                 idle;
   logic                 done;
   logic                 take;
   logic [OPER_W-1:0]    result;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OPER_W-1:0]    r_ff, r_in;

   assign start = req_chan.valid & idle;
   assign take  = done & (~rsp_valid_ff | rsp_chan.ready);

   mma_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .act    (act_type'(req_chan.action)),
      .a      ({req_chan.a_w3, req_chan.a_w2, req_chan.a_w1, req_chan.a_w0}),
      .b      ({req_chan.b_w3, req_chan.b_w2, req_chan.b_w1, req_chan.b_w0}),
      .take   (take),
      .idle   (idle),
      .done   (done),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = take | (rsp_valid_ff & ~rsp_chan.ready);
      r_in         = take ? result : r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign req_chan.ready = idle;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.r_w0  = r_ff[WORD_W-1:0];
   assign rsp_chan.r_w1  = r_ff[2*WORD_W-1:WORD_W];
   assign rsp_chan.r_w2  = r_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_chan.r_w3  = r_ff[4*WORD_W-1:3*WORD_W];

endmodule

// ===== src/mma_checker.sv =====
// port-level checks for the arithmetic unit, bound to the top level
module mma_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready while a transaction is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after accept");

endmodule

bind modn_montgomery_alu_256 mma_checker u_mma_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
